@@ hw/rtl/scba_pkg.sv @@
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, codes and class table for the size-class block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package scba_pkg;

   localparam int NUM_CLASSES = 14;
   localparam int CLASS_W     = 4;
   localparam int SIZE_W      = 16;
   localparam int ADDR_W      = 17;
   localparam int SLOT_W      = 13;              // 16-byte slots in the address space
   localparam int LINK_W      = 14;              // slot+1, zero marks end of list
   localparam int SLOT_COUNT  = 1 << SLOT_W;
   localparam int CSLOT_W     = 6;               // class size in slots, max 40

   localparam logic [SIZE_W-1:0] MAX_CLASS_BYTES = 16'd640;

   // class sizes in 16-byte slots
   localparam logic [CSLOT_W-1:0] CLASS_SLOTS [NUM_CLASSES] = '{
      6'd1, 6'd2, 6'd4, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14,
      6'd16, 6'd20, 6'd24, 6'd28, 6'd32, 6'd40
   };

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_SIZE = 2'd1,
      ST_TOO_BIG   = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      RES_ZERO,      // ok, address zero
      RES_SIZE_ERR,  // size status, address zero
      RES_EXHAUST,
      RES_POP,
      RES_CARVE
   } res_sel_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECODE = 4'b0010,
      S_POP    = 4'b0100,
      S_CARVE  = 4'b1000
   } state_type;

   typedef struct packed {
      logic        load;
      logic        pop_issue;
      logic        pop_done;
      logic        free_push;
      logic        clear_all;
      logic        carve_init;
      logic        carve_write;
      logic        finish;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         size_err;
      logic         head_empty;
      logic         no_chunk;
      logic         in_arena;
      logic         carve_last;
   } stat_type;

   // smallest class whose size fits, sizes in bytes
   function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
      logic [CLASS_W-1:0] k;
      k = CLASS_W'(NUM_CLASSES - 1);
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (size <= {6'd0, CLASS_SLOTS[i], 4'd0})
            k = CLASS_W'(i);
      end
      return k;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/size_class_block_allocator.sv @@
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Segregated free-list allocator: 14 size classes (16..640 bytes) carved
// from a fixed arena of equal chunks.
//
//   channel   ports                                    handshake
//   request   req_type, req_size, req_free_addr        start & !busy
//   response  rsp_block_addr, rsp_status               rsp_valid, one cycle
//
// Flow: free, clear and rejected requests answer from the decode state, a
// list pop goes through the pop state for the registered link RAM read,
// and a chunk carve writes one link per block carved in the carve state
// (link RAM single write port).
// Reset clears list heads and the chunk count; link RAM needs no clearing.
// The response cannot be stalled; busy drops in the cycle of the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_block_allocator
   import scba_pkg::*;
#(
   parameter int CHUNK_BYTES = 16384,  // 1024..65536
   parameter int NUM_CHUNKS  = 8       // 1..64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_type,
   input  wire logic [SIZE_W-1:0] req_size,
   input  wire logic [ADDR_W-1:0] req_free_addr,
   output logic                   rsp_valid,
   output logic [ADDR_W-1:0]      rsp_block_addr,
   output logic [1:0]             rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: owns busy and the per-request flow
   scba_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   // datapath: class lists, link memory, carve walk, result registers
   scba_dpath #(
      .CHUNK_BYTES(CHUNK_BYTES),
      .NUM_CHUNKS (NUM_CHUNKS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req_type),
      .req_size      (req_size),
      .req_free_addr (req_free_addr),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_block_addr(rsp_block_addr),
      .rsp_status    (rsp_status)
   );

   // an accepted request always occupies the sequencer next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // failed allocations never return an address
   a_err_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_block_addr == '0))
      else $error("nonzero address with error status");

   // strobe only appears once the sequencer is back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // one response per request: never two strobes back to back
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("double response strobe");

endmodule

`default_nettype wire

@@ hw/rtl/scba_ram.sv @@
// ----------------------------------------------------------------------------
// scba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/scba_ctrl.sv @@
// ----------------------------------------------------------------------------
// scba_ctrl
// Request sequencer: decode, list pop, chunk carve walk, result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_ctrl
   import scba_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_sel = RES_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            unique case (stat.kind)
               REQ_ALLOC: begin
                  if (stat.size_err) begin
                     cmd.finish  = 1'b1;
                     cmd.res_sel = RES_SIZE_ERR;
                  end else if (!stat.head_empty) begin
                     cmd.pop_issue = 1'b1;
                     state_in      = S_POP;
                  end else if (stat.no_chunk) begin
                     cmd.finish  = 1'b1;
                     cmd.res_sel = RES_EXHAUST;
                  end else begin
                     cmd.carve_init = 1'b1;
                     state_in       = S_CARVE;
                  end
               end
               REQ_FREE: begin
                  cmd.finish    = 1'b1;
                  cmd.res_sel   = stat.size_err ? RES_SIZE_ERR : RES_ZERO;
                  cmd.free_push = !stat.size_err && stat.in_arena;
               end
               REQ_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  cmd.finish    = 1'b1;
               end
               default: begin
                  cmd.finish = 1'b1;
               end
            endcase
         end
         S_POP: begin
            cmd.pop_done = 1'b1;
            cmd.finish   = 1'b1;
            cmd.res_sel  = RES_POP;
            state_in     = S_IDLE;
         end
         S_CARVE: begin
            cmd.carve_write = 1'b1;
            if (stat.carve_last) begin
               cmd.finish  = 1'b1;
               cmd.res_sel = RES_CARVE;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/scba_dpath.sv @@
// ----------------------------------------------------------------------------
// scba_dpath
// List heads, chunk pointer, carve counters, link RAM and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_dpath
   import scba_pkg::*;
#(
   parameter int CHUNK_BYTES = 16384,
   parameter int NUM_CHUNKS  = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        req_type,
   input  wire logic [SIZE_W-1:0] req_size,
   input  wire logic [ADDR_W-1:0] req_free_addr,
   input  wire cmd_type           cmd,
   output stat_type               stat,
   output logic                   rsp_valid,
   output logic [ADDR_W-1:0]      rsp_block_addr,
   output logic [1:0]             rsp_status
);

   localparam int STRIDE_BYTES = ((CHUNK_BYTES + 15) / 16) * 16;
   localparam int FIT_CHUNKS   = (1 << ADDR_W) / STRIDE_BYTES;
   localparam int ARENA_CHUNKS = (NUM_CHUNKS < FIT_CHUNKS) ? NUM_CHUNKS : FIT_CHUNKS;
   localparam int ARENA_BYTES  = ARENA_CHUNKS * STRIDE_BYTES;
   localparam int STRIDE_SLOTS = STRIDE_BYTES / 16;
   localparam int CHUNK_SLOTS  = CHUNK_BYTES / 16;   // whole slots usable for blocks
   localparam int CNT_W        = $clog2(ARENA_CHUNKS + 1);
   localparam int OFF_W        = 14;                 // offset in slots, max 4096 plus step

   localparam logic [ADDR_W:0]  ARENA_END  = (ADDR_W+1)'(ARENA_BYTES);
   localparam logic [CNT_W-1:0] ARENA_CNT  = CNT_W'(ARENA_CHUNKS);
   localparam logic [OFF_W:0]   CHUNK_SL   = (OFF_W+1)'(CHUNK_SLOTS);
   localparam logic [LINK_W-1:0] STRIDE_SL = LINK_W'(STRIDE_SLOTS);

   // request context
   logic [1:0]        kind_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [ADDR_W-1:0] faddr_ff;

   // allocator state
   logic [LINK_W-1:0] head_ff [NUM_CLASSES];
   logic [CNT_W-1:0]  chunks_ff;
   logic [LINK_W-1:0] base_ff;          // first slot of next chunk

   // work registers
   logic [SLOT_W-1:0] pop_slot_ff;
   logic [SLOT_W-1:0] cur_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [SLOT_W-1:0] carve_base_ff;

   // result
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [1:0]        rsp_status_ff;

   logic [CLASS_W-1:0] cls;
   logic [CSLOT_W-1:0] bsl;
   logic [LINK_W-1:0]  head_cur;
   logic [1:0]         size_code;
   logic               carve_last;
   logic               multi;
   logic [LINK_W-1:0]  link_rd;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [LINK_W-1:0] wr_data;

   assign cls      = class_of(size_ff);
   assign bsl      = CLASS_SLOTS[cls];
   assign head_cur = head_ff[cls];

   always_comb begin
      if (size_ff == '0)
         size_code = ST_ZERO_SIZE;
      else if (size_ff > MAX_CLASS_BYTES)
         size_code = ST_TOO_BIG;
      else
         size_code = ST_OK;
   end

   // next block would run past the usable part of the chunk
   assign carve_last = ({1'b0, off_ff} + (OFF_W+1)'({bsl, 1'b0})) > CHUNK_SL;
   assign multi      = (OFF_W+1)'({bsl, 1'b0}) <= CHUNK_SL;

   always_comb begin
      stat.kind       = req_kind_type'(kind_ff);
      stat.size_err   = (size_code != ST_OK);
      stat.head_empty = (head_cur == '0);
      stat.no_chunk   = (chunks_ff >= ARENA_CNT) || ((OFF_W+1)'(bsl) > CHUNK_SL);
      stat.in_arena   = ({1'b0, faddr_ff} < ARENA_END);
      stat.carve_last = carve_last;
   end

   // link RAM write port: free push or carve step
   always_comb begin
      wr_en   = cmd.free_push || cmd.carve_write;
      wr_addr = cmd.free_push ? faddr_ff[ADDR_W-1:4] : cur_ff;
      if (cmd.free_push)
         wr_data = head_cur;
      else if (carve_last)
         wr_data = '0;
      else
         wr_data = {1'b0, cur_ff} + LINK_W'(bsl) + LINK_W'(1);
   end

   scba_ram #(
      .WIDTH(LINK_W),
      .DEPTH(SLOT_COUNT)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.pop_issue),
      .rd_addr(SLOT_W'(head_cur - LINK_W'(1))),
      .rd_data(link_rd)
   );

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_type;
         size_ff  <= req_size;
         faddr_ff <= req_free_addr;
      end
   end

   // list heads and chunk pointer
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         for (int i = 0; i < NUM_CLASSES; i++)
            head_ff[i] <= '0;
         chunks_ff <= '0;
         base_ff   <= '0;
      end else begin
         if (cmd.pop_done)
            head_ff[cls] <= link_rd;
         else if (cmd.free_push)
            head_ff[cls] <= {1'b0, faddr_ff[ADDR_W-1:4]} + LINK_W'(1);
         else if (cmd.carve_init)
            head_ff[cls] <= multi ? (base_ff + LINK_W'(bsl) + LINK_W'(1)) : '0;
         if (cmd.carve_init) begin
            chunks_ff <= chunks_ff + CNT_W'(1);
            base_ff   <= base_ff + STRIDE_SL;
         end
      end
   end

   // pop slot and carve walk
   always_ff @(posedge clock) begin
      if (cmd.pop_issue)
         pop_slot_ff <= SLOT_W'(head_cur - LINK_W'(1));
      if (cmd.carve_init) begin
         cur_ff        <= base_ff[SLOT_W-1:0];
         carve_base_ff <= base_ff[SLOT_W-1:0];
         off_ff        <= '0;
      end else if (cmd.carve_write) begin
         cur_ff <= cur_ff + SLOT_W'(bsl);
         off_ff <= off_ff + OFF_W'(bsl);
      end
   end

   // result register, one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= cmd.finish;
      if (cmd.finish) begin
         case (cmd.res_sel)
            RES_SIZE_ERR: begin
               rsp_addr_ff   <= '0;
               rsp_status_ff <= size_code;
            end
            RES_EXHAUST: begin
               rsp_addr_ff   <= '0;
               rsp_status_ff <= ST_EXHAUSTED;
            end
            RES_POP: begin
               rsp_addr_ff   <= {pop_slot_ff, 4'd0};
               rsp_status_ff <= ST_OK;
            end
            RES_CARVE: begin
               rsp_addr_ff   <= {carve_base_ff, 4'd0};
               rsp_status_ff <= ST_OK;
            end
            default: begin
               rsp_addr_ff   <= '0;
               rsp_status_ff <= ST_OK;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_addr = rsp_addr_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the size-class block allocator. A generator fills
// a request queue (directed corner cases first, then random allocate/free/
// clear/unused-type traffic that recycles live blocks). A clocked driver issues the
// requests, and a behavioral free-list predictor runs on every accepted one.
// A clocked monitor compares each response strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import scba_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // arena setup, matches the DUT parameter defaults
   localparam int CHUNK_BYTES  = 16384;
   localparam int NUM_CHUNKS   = 8;
   localparam int CHUNK_STRIDE = (CHUNK_BYTES + 15) & ~15;
   localparam int FIT_CHUNKS   = 131072 / CHUNK_STRIDE;
   localparam int ARENA_CHUNKS = (NUM_CHUNKS < FIT_CHUNKS) ? NUM_CHUNKS : FIT_CHUNKS;
   localparam int RANDOM_REQS  = 1780;
   localparam int QUIET_TAIL   = 200;   // final stretch without idle bursts

   typedef struct {
      req_kind_type        kind;
      logic [SIZE_W-1:0]   size;
      logic [ADDR_W-1:0]   addr;
   } request_type;

   typedef struct {
      logic [ADDR_W-1:0]   addr;
      status_type          status;
      logic [SIZE_W-1:0]   size;
      logic                is_alloc;
   } response_type;

   typedef struct {
      logic [ADDR_W-1:0]   addr;
      logic [SIZE_W-1:0]   size;
   } block_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_type;
   logic [SIZE_W-1:0]   req_size;
   logic [ADDR_W-1:0]   req_free_addr;
   logic                rsp_valid;
   logic [ADDR_W-1:0]   rsp_block_addr;
   logic [1:0]          rsp_status;

   request_type         pending_req_q[$];
   response_type        expected_rsp_q[$];
   block_type           live_blocks[$];
   request_type         cur_req;
   bit                  failed;
   bit                  quiet;
   int                  idle_left;

   // predictor state: free-list heads (slot+1, 0 = empty), links, chunk count
   logic [LINK_W-1:0]   list_head [NUM_CLASSES];
   logic [LINK_W-1:0]   next_link [SLOT_COUNT];
   int                  chunks_used;

   int                  class_bytes [NUM_CLASSES] = '{
      16, 32, 64, 96, 128, 160, 192, 224, 256, 320, 384, 448, 512, 640
   };

   size_class_block_allocator i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_size       (req_size),
      .req_free_addr  (req_free_addr),
      .rsp_valid      (rsp_valid),
      .rsp_block_addr (rsp_block_addr),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // smallest class that holds size bytes; sizes above 640 never get here
   function automatic int size_class(input int size);
      int k;
      k = NUM_CLASSES - 1;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (size <= class_bytes[i])
            k = i;
      end
      return k;
   endfunction

   // advance the free-list state by one request and produce its response
   task automatic allocator_step(input request_type r, output response_type e);
      int k, bs, cnt, base, slot, s;
      e.addr     = '0;
      e.status   = ST_OK;
      e.size     = r.size;
      e.is_alloc = (r.kind == REQ_ALLOC);
      case (r.kind)
         REQ_ALLOC: begin
            if (r.size == 0) begin
               e.status = ST_ZERO_SIZE;
            end else if (r.size > 640) begin
               e.status = ST_TOO_BIG;
            end else begin
               k = size_class(r.size);
               if (list_head[k] != 0) begin
                  // pop the list
                  slot         = list_head[k] - 1;
                  list_head[k] = next_link[slot];
                  e.addr       = ADDR_W'(slot * 16);
               end else begin
                  bs  = class_bytes[k];
                  cnt = CHUNK_BYTES / bs;
                  if (chunks_used >= ARENA_CHUNKS || cnt == 0) begin
                     e.status = ST_EXHAUSTED;
                  end else begin
                     // carve a fresh chunk, blocks linked in address order
                     base = chunks_used * CHUNK_STRIDE;
                     for (int i = 0; i < cnt; i++) begin
                        s = (base + i * bs) / 16;
                        if (s < SLOT_COUNT)
                           next_link[s] = (i + 1 < cnt) ?
                              LINK_W'((base + (i + 1) * bs) / 16 + 1) : '0;
                     end
                     list_head[k] = (cnt > 1) ? LINK_W'((base + bs) / 16 + 1) : '0;
                     chunks_used++;
                     e.addr = ADDR_W'(base);
                  end
               end
            end
         end
         REQ_FREE: begin
            if (r.size == 0) begin
               e.status = ST_ZERO_SIZE;
            end else if (r.size > 640) begin
               e.status = ST_TOO_BIG;
            end else if (int'(r.addr) < ARENA_CHUNKS * CHUNK_STRIDE) begin
               // no liveness or class check: push at the 16-byte slot
               slot            = r.addr >> 4;
               k               = size_class(r.size);
               next_link[slot] = list_head[k];
               list_head[k]    = LINK_W'(slot + 1);
            end
         end
         REQ_CLEAR: begin
            foreach (list_head[i])
               list_head[i] = '0;
            chunks_used = 0;
         end
         default: ;  // unused type: no effect
      endcase
   endtask

   // driver: predicts on acceptance, then holds, idles or presents the next
   always @(posedge clock) begin
      response_type exp_rsp;
      if (reset) begin
         start         <= 1'b0;
         req_type      <= REQ_ALLOC;
         req_size      <= '0;
         req_free_addr <= '0;
         idle_left     = 0;
         foreach (list_head[i])
            list_head[i] = '0;
         chunks_used   = 0;
      end else if (start && busy) begin
         // request still waiting for acceptance
      end else begin
         if (start) begin
            allocator_step(cur_req, exp_rsp);
            expected_rsp_q.push_back(exp_rsp);
            if (!quiet && idle_left == 0 && $urandom_range(0, 4) == 0)
               idle_left = $urandom_range(1, 6);
         end
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_req_q.size() > 0) begin
            cur_req = pending_req_q.pop_front();
            start         <= 1'b1;
            req_type      <= cur_req.kind;
            req_size      <= cur_req.size;
            req_free_addr <= cur_req.addr;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: one response per strobe, checked against the oldest prediction
   always @(posedge clock) begin
      response_type exp_rsp;
      block_type    blk;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response addr=%0h status=%0d",
                     $time, rsp_block_addr, rsp_status);
            failed = 1'b1;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_block_addr !== exp_rsp.addr) begin
               $display("%0t: block_addr expected %0h actual %0h",
                        $time, exp_rsp.addr, rsp_block_addr);
               failed = 1'b1;
            end
            if (rsp_status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_rsp.status, rsp_status);
               failed = 1'b1;
            end
            // successful allocations feed the pool of blocks to free later
            if (exp_rsp.is_alloc && exp_rsp.status == ST_OK) begin
               blk.addr = exp_rsp.addr;
               blk.size = exp_rsp.size;
               live_blocks.push_back(blk);
            end
         end
      end
   end

   task automatic queue_request(input req_kind_type kind, input int size, input int addr);
      request_type r;
      r.kind = kind;
      r.size = SIZE_W'(size);
      r.addr = ADDR_W'(addr);
      // keep the queue short so frees can draw on recently returned blocks
      while (pending_req_q.size() > 2)
         @(posedge clock);
      pending_req_q.push_back(r);
   endtask

   function automatic int random_size();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         return 0;
      if (pick < 8)
         return $urandom_range(641, 65535);
      if (pick < 11)
         return $urandom_range(0, 65535);
      return $urandom_range(1, 640);
   endfunction

   task automatic drain_responses();
      while (pending_req_q.size() > 0 || start || expected_rsp_q.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int        pick, idx;
      block_type blk;
      failed = 1'b0;
      quiet  = 1'b0;
      @(negedge reset);

      // directed: rejects, class edges, unused type
      queue_request(REQ_ALLOC, 0, 0);
      queue_request(REQ_ALLOC, 641, 0);
      queue_request(REQ_ALLOC, 65535, 0);
      queue_request(REQ_ALLOC, 640, 0);
      queue_request(REQ_ALLOC, 513, 0);
      queue_request(REQ_FREE, 0, 17'h1FFFF);
      queue_request(REQ_FREE, 65535, 17'h1FFFF);
      queue_request(REQ_NONE, 65535, 17'h1FFFF);
      // misaligned free lands at its slot, next alloc pops it back
      queue_request(REQ_FREE, 640, 17'h00285);
      queue_request(REQ_ALLOC, 600, 0);
      // one carve per class until the arena runs out
      queue_request(REQ_ALLOC, 512, 0);
      queue_request(REQ_ALLOC, 448, 0);
      queue_request(REQ_ALLOC, 384, 0);
      queue_request(REQ_ALLOC, 320, 0);
      queue_request(REQ_ALLOC, 256, 0);
      queue_request(REQ_ALLOC, 224, 0);
      queue_request(REQ_ALLOC, 192, 0);
      queue_request(REQ_ALLOC, 160, 0);
      queue_request(REQ_ALLOC, 1, 0);
      queue_request(REQ_FREE, 16, 17'h1FFF0);
      queue_request(REQ_ALLOC, 16, 0);
      queue_request(REQ_CLEAR, 0, 0);
      queue_request(REQ_ALLOC, 17, 0);
      drain_responses();
      live_blocks.delete();

      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n == RANDOM_REQS / 2)
            drain_responses();  // let the block go fully idle once
         if (n == RANDOM_REQS - QUIET_TAIL)
            quiet = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            queue_request(REQ_ALLOC, random_size(), $urandom_range(0, 131071));
         end else if (pick < 85 && live_blocks.size() > 0) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[idx];
            live_blocks.delete(idx);
            // occasionally return it with stray low address bits
            if ($urandom_range(0, 7) == 0)
               blk.addr = blk.addr | ADDR_W'($urandom_range(1, 15));
            queue_request(REQ_FREE, blk.size, blk.addr);
         end else if (pick < 94) begin
            queue_request(REQ_FREE, random_size(), $urandom_range(0, 131071));
         end else if (pick < 97) begin
            queue_request(REQ_NONE, $urandom_range(0, 65535), $urandom_range(0, 131071));
         end else begin
            queue_request(REQ_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 131071));
            live_blocks.delete();
         end
      end

      drain_responses();
      repeat (20) @(posedge clock);
      if (failed || expected_rsp_q.size() != 0) begin
         $display("FAIL");
      end else begin
         $display("PASS");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("FAIL");
      $finish;
   end

endmodule
